### rtl/tcst_pkg.sv
// Package with state codes, flag positions and next-state functions of the TCP state tracker.
`timescale 1ns / 1ps

package tcst_pkg;

    typedef logic [3:0] tcp_state_t;
    typedef logic [7:0] tcp_flags_t;

    localparam tcp_state_t ST_CLOSED     = 4'd0;
    localparam tcp_state_t ST_LISTEN     = 4'd1;
    localparam tcp_state_t ST_SYN_SENT   = 4'd2;
    localparam tcp_state_t ST_SYN_RCVD   = 4'd3;
    localparam tcp_state_t ST_ESTAB      = 4'd4;
    localparam tcp_state_t ST_FW1        = 4'd5;
    localparam tcp_state_t ST_FW2        = 4'd6;
    localparam tcp_state_t ST_CLOSE_WAIT = 4'd7;
    localparam tcp_state_t ST_CLOSING    = 4'd8;
    localparam tcp_state_t ST_LAST_ACK   = 4'd9;
    localparam tcp_state_t ST_TWAIT      = 4'd10;

    localparam int FIN_BIT = 0;
    localparam int SYN_BIT = 1;
    localparam int RST_BIT = 2;
    localparam int ACK_BIT = 4;

    localparam tcp_flags_t FLAGS_SYN     = 8'h02;
    localparam tcp_flags_t FLAGS_ACK     = 8'h10;
    localparam tcp_flags_t FLAGS_SYN_ACK = 8'h12;

    // Next state of the end that sends the segment; peer is the other end's old state.
    function automatic tcp_state_t send_next(tcp_state_t s, tcp_flags_t f, tcp_state_t peer);
        tcp_state_t n;
        n = s;
        if (f[RST_BIT])
        begin
            n = ST_TWAIT;
        end
        else
        begin
            case (s)
                ST_CLOSED:
                begin
                    if (f == FLAGS_SYN) n = ST_SYN_SENT;
                end
                ST_LISTEN:
                begin
                    if (peer == ST_SYN_SENT && f == FLAGS_SYN_ACK) n = ST_SYN_RCVD;
                    else if (f == FLAGS_SYN) n = ST_SYN_SENT;
                end
                ST_SYN_SENT:
                begin
                    if (peer == ST_SYN_RCVD && f == FLAGS_ACK) n = ST_ESTAB;
                end
                ST_SYN_RCVD:
                begin
                    if (f[FIN_BIT]) n = ST_FW1;
                end
                ST_ESTAB:
                begin
                    if (peer == ST_FW1 && f[ACK_BIT]) n = ST_CLOSE_WAIT;
                    else if (f[FIN_BIT]) n = ST_FW1;
                end
                ST_CLOSE_WAIT:
                begin
                    if (f[FIN_BIT]) n = ST_LAST_ACK;
                end
                ST_FW1:
                begin
                    if (peer == ST_CLOSE_WAIT && f[ACK_BIT]) n = ST_CLOSING;
                end
                ST_FW2:
                begin
                    if (f[ACK_BIT]) n = ST_TWAIT;
                end
                default:
                begin
                    n = s;
                end
            endcase
        end
        return n;
    endfunction

    // Next state of the end that receives the segment.
    function automatic tcp_state_t recv_next(tcp_state_t s, tcp_flags_t f);
        tcp_state_t n;
        n = s;
        if (f[RST_BIT])
        begin
            n = ST_CLOSED;
        end
        else
        begin
            case (s)
                ST_LISTEN:
                begin
                    if (f == FLAGS_SYN) n = ST_SYN_RCVD;
                end
                ST_SYN_SENT:
                begin
                    if (f == FLAGS_SYN_ACK) n = ST_ESTAB;
                    else if (f == FLAGS_SYN) n = ST_SYN_RCVD;
                end
                ST_SYN_RCVD:
                begin
                    if (f == FLAGS_ACK) n = ST_ESTAB;
                end
                ST_ESTAB:
                begin
                    if (f[FIN_BIT]) n = ST_CLOSE_WAIT;
                end
                ST_LAST_ACK:
                begin
                    if (f[ACK_BIT]) n = ST_CLOSED;
                end
                ST_FW1:
                begin
                    if (f[FIN_BIT] && f[ACK_BIT]) n = ST_TWAIT;
                    else if (f[FIN_BIT]) n = ST_CLOSING;
                    else if (f[ACK_BIT]) n = ST_FW2;
                end
                ST_FW2:
                begin
                    if (f[FIN_BIT]) n = ST_TWAIT;
                end
                ST_CLOSING:
                begin
                    if (f[ACK_BIT]) n = ST_TWAIT;
                end
                default:
                begin
                    n = s;
                end
            endcase
        end
        return n;
    endfunction

endpackage

### rtl/tcp_connection_state_tracker.sv
// Top level of the TCP connection state tracker: input register, state update and result register.
// A request is held in the input register until the result register can take its result.
// One request per cycle unless m_tready stalls; the two 4-bit state registers update together.
// The input register takes a new request in while a result still waits to be taken.
// Reset: the client end starts CLOSED and the server end starts LISTEN, both stages empty.
`timescale 1ns / 1ps

module tcp_connection_state_tracker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] seg_flags
    input  logic [0:0]  s_tuser,   // [0] from_server
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] result_code, [4:1] client_now, [8:5] server_now, rest 0
);
    import tcst_pkg::*;

    logic       in_valid_reg;
    tcp_flags_t flags_reg;
    logic       dir_reg;

    tcp_state_t client_state_reg;
    tcp_state_t client_state_next;
    tcp_state_t server_state_reg;
    tcp_state_t server_state_next;
    logic       code_next;

    logic       out_valid_reg;
    logic       code_reg;
    tcp_state_t client_out_reg;
    tcp_state_t server_out_reg;

    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            flags_reg <= s_tdata;
            dir_reg   <= s_tuser[0];
        end
    end

    // The sender uses the receiver's old state; the receiver uses only its own state and the flags.
    always_comb
    begin
        if (!dir_reg)
        begin
            client_state_next = send_next(client_state_reg, flags_reg, server_state_reg);
            server_state_next = recv_next(server_state_reg, flags_reg);
            code_next = (server_state_reg == ST_SYN_RCVD) && flags_reg[SYN_BIT]
                        && !flags_reg[RST_BIT];
        end
        else
        begin
            server_state_next = send_next(server_state_reg, flags_reg, client_state_reg);
            client_state_next = recv_next(client_state_reg, flags_reg);
            code_next = (client_state_reg == ST_SYN_RCVD) && flags_reg[SYN_BIT]
                        && !flags_reg[RST_BIT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            client_state_reg <= ST_CLOSED;
            server_state_reg <= ST_LISTEN;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                client_state_reg <= client_state_next;
                server_state_reg <= server_state_next;
                out_valid_reg    <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            code_reg       <= code_next;
            client_out_reg <= client_state_next;
            server_out_reg <= server_state_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, server_out_reg, client_out_reg, code_reg};

    // The shown result always reflects the tracked connection state.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (client_out_reg == client_state_reg
                           && server_out_reg == server_state_reg))
        else $error("result register out of step with state registers");

    // Only the defined state codes are ever reached.
    assert property (@(posedge clk) disable iff (!rst_n)
        client_state_reg <= ST_TWAIT && server_state_reg <= ST_TWAIT)
        else $error("state register holds an undefined code");

    // A SYN seen in SYN_RCVD leaves the receiver there.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && code_reg) |->
            (client_out_reg == ST_SYN_RCVD || server_out_reg == ST_SYN_RCVD))
        else $error("SYN code without a receiver in SYN_RCVD");

    // The connection state moves only when a request is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(client_state_reg) && $stable(server_state_reg)))
        else $error("state changed without a request");

endmodule
